// ===== design/sts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted timeout scheduler.
// Depends on nothing; every other file of the block imports it.
package sts_pkg;

    // Field widths of the item and result transfers.
    localparam int TIME_W = 32;
    localparam int DUR_W  = 31;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 2;

    // Default table size and the limit on expiries per tick.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int KW             = $clog2(MAX_OUT + 1);

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRITE,
        ST_SET_OUT,
        ST_TICK
    } t_state;

    // One stored timeout, apart from its link.
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
        logic              cls;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic track_head;
        logic start_set;
        logic start_tick;
        logic walk;
        logic write_slot;
        logic link_prev;
        logic out_set;
        logic pop;
        logic out_exp;
        logic out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic found;
        logic walk_done;
        logic out_free;
        logic k_zero;
        logic next_due;
    } t_dp_sts;

endpackage

// ===== design/sts_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the sorted timeout scheduler: item input and result output.
// Depends on sts_pkg for the field widths.
interface sts_in_if import sts_pkg::*;;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [DUR_W-1:0] duration;
    logic [TAG_W-1:0] tag;
    logic             callback_class;

    modport source (output valid, mode, duration, tag, callback_class, input ready);
    modport sink   (input valid, mode, duration, tag, callback_class, output ready);
endinterface

interface sts_out_if import sts_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  out_tag;
    logic              out_class;
    logic [TIME_W-1:0] deadline;
    logic              last;

    modport source (output valid, kind, out_tag, out_class, deadline, last, input ready);
    modport sink   (input valid, kind, out_tag, out_class, deadline, last, output ready);
endinterface

// ===== design/sts_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the sorted timeout scheduler: time counter, entry memories, busy bits,
// free-slot scan, list walk and the result register. Depends on sts_pkg.
module sts_datapath import sts_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [DUR_W-1:0]  i_duration,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic              i_class,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [KIND_W-1:0] o_kind,
    output logic [TAG_W-1:0]  o_tag,
    output logic              o_class,
    output logic [TIME_W-1:0] o_deadline,
    output logic              o_last
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam logic [PW-1:0] EMPTY     = PW'(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    // Entry memories; a link equal to EMPTY ends the list.
    t_entry              r_pay_mem  [SLOT_COUNT];
    logic [PW-1:0]       r_link_mem [SLOT_COUNT];

    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_when;
    logic [TAG_W-1:0]    r_tag;
    logic                r_class;
    logic [SLOT_COUNT-1:0] r_busy;
    logic [PW-1:0]       r_head;
    logic [IW-1:0]       r_free;
    logic [PW-1:0]       r_cur;
    logic [PW-1:0]       n_cur;
    logic [PW-1:0]       r_prev;
    logic [IW-1:0]       r_scan;
    logic [IW-1:0]       r_scan_cnt;
    logic                r_scan_done;
    logic                r_found;
    logic                r_walk_done;
    logic [KW-1:0]       r_k;
    t_entry              r_rd_pay;
    logic [PW-1:0]       r_rd_link;
    t_entry              r_pend;
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    t_entry              r_out_pay;
    logic                r_out_last;

    logic                cur_valid;
    logic                prev_valid;
    logic [TIME_W-1:0]   diff_new;
    logic [TIME_W-1:0]   diff_now;
    logic                new_first;
    logic                is_due;
    logic                walk_adv;
    logic                out_free;
    logic [IW-1:0]       rd_idx;

    // Ordering and due tests on the entry that was just read.
    assign cur_valid  = r_cur < EMPTY;
    assign prev_valid = r_prev < EMPTY;
    assign diff_new   = r_when - r_rd_pay.deadline;
    assign diff_now   = r_time - r_rd_pay.deadline;
    assign new_first  = diff_new[TIME_W-1];
    assign is_due     = !diff_now[TIME_W-1];
    assign walk_adv   = i_cmd.walk && !r_walk_done && cur_valid && !new_first;
    assign out_free   = !r_out_valid || i_out_ready;

    // The read address is the cursor's next value, so the read data always matches r_cur.
    always_comb begin
        if (i_cmd.track_head) begin
            n_cur = r_head;
        end else if (walk_adv || i_cmd.pop) begin
            n_cur = r_rd_link;
        end else begin
            n_cur = r_cur;
        end
    end

    assign rd_idx = (n_cur < EMPTY) ? n_cur[IW-1:0] : '0;

    // Status towards the controller.
    always_comb begin
        o_sts.scan_done = r_scan_done;
        o_sts.found     = r_found;
        o_sts.walk_done = r_walk_done;
        o_sts.out_free  = out_free;
        o_sts.k_zero    = (r_k == '0);
        o_sts.next_due  = cur_valid && is_due && (r_k < KW'(MAX_OUT));
    end

    // Entry memories: one write port each, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_slot) begin
            r_pay_mem[r_scan]  <= '{deadline: r_when, tag: r_tag, cls: r_class};
            r_link_mem[r_scan] <= r_cur;
        end else if (i_cmd.link_prev && prev_valid) begin
            r_link_mem[r_prev[IW-1:0]] <= PW'(r_scan);
        end
        r_rd_pay  <= r_pay_mem[rd_idx];
        r_rd_link <= r_link_mem[rd_idx];
    end

    // Control state: time, busy bits, list head, scan and walk progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_busy      <= '0;
            r_head      <= EMPTY;
            r_free      <= '0;
            r_cur       <= EMPTY;
            r_prev      <= EMPTY;
            r_scan      <= '0;
            r_scan_cnt  <= '0;
            r_scan_done <= 1'b0;
            r_found     <= 1'b0;
            r_walk_done <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur <= n_cur;

            if (i_cmd.start_tick) begin
                r_time <= r_time + 1'b1;
                r_k    <= '0;
            end

            if (i_cmd.start_set) begin
                r_scan      <= r_free;
                r_scan_cnt  <= '0;
                r_scan_done <= 1'b0;
                r_found     <= 1'b0;
                r_walk_done <= 1'b0;
                r_prev      <= EMPTY;
            end

            // One slot of the round-robin free search per cycle.
            if (i_cmd.walk && !r_scan_done) begin
                if (!r_busy[r_scan]) begin
                    r_scan_done <= 1'b1;
                    r_found     <= 1'b1;
                end else if (r_scan_cnt == LAST_SLOT) begin
                    r_scan_done <= 1'b1;
                end else begin
                    r_scan     <= (r_scan == LAST_SLOT) ? '0 : r_scan + 1'b1;
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
            end

            // One list entry of the insertion walk per cycle.
            if (i_cmd.walk && !r_walk_done) begin
                if (walk_adv) begin
                    r_prev <= r_cur;
                end else begin
                    r_walk_done <= 1'b1;
                end
            end

            if (i_cmd.write_slot) begin
                r_busy[r_scan] <= 1'b1;
                r_free         <= r_scan;
                if (!prev_valid) begin
                    r_head <= PW'(r_scan);
                end
            end

            if (i_cmd.pop) begin
                r_busy[r_cur[IW-1:0]] <= 1'b0;
                r_head                <= r_rd_link;
                r_k                   <= r_k + 1'b1;
            end

            if (i_cmd.out_set || i_cmd.out_exp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, pending expiry and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_set) begin
            r_when  <= r_time + {1'b0, i_duration};
            r_tag   <= i_tag;
            r_class <= i_class;
        end
        if (i_cmd.pop) begin
            r_pend <= r_rd_pay;
        end
        if (i_cmd.out_set) begin
            r_out_kind <= r_found ? KIND_ACCEPTED : KIND_REJECTED;
            r_out_pay  <= '{deadline: r_when, tag: r_tag, cls: r_class};
            r_out_last <= 1'b1;
        end else if (i_cmd.out_exp) begin
            r_out_kind <= KIND_EXPIRED;
            r_out_pay  <= r_pend;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_tag       = r_out_pay.tag;
    assign o_class     = r_out_pay.cls;
    assign o_deadline  = r_out_pay.deadline;
    assign o_last      = r_out_last;

    // A non-empty list always starts at an occupied slot.
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < EMPTY) |-> r_busy[r_head[IW-1:0]])
        else $error("list head points at a free slot");

    // Only an occupied entry at the cursor can be removed.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (cur_valid && r_busy[r_cur[IW-1:0]]))
        else $error("expiry taken from an invalid cursor");

    // A new timeout is only written into a free slot that the scan found.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_slot |-> (r_found && r_scan_done && r_walk_done && !r_busy[r_scan]))
        else $error("slot written without a completed free search");

    // A result is never loaded over one that has not been transferred.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_set || i_cmd.out_exp) |-> out_free)
        else $error("result register overwritten");

    // Expiries per tick stay within the limit.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_OUT))
        else $error("too many expiries in one tick");

endmodule

// ===== design/sts_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the sorted timeout scheduler: sequences set and tick items.
// Depends on sts_pkg for the state, command and status types.
module sts_ctrl import sts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.track_head = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.start_set = 1'b1;
                        n_state         = ST_WALK;
                    end else begin
                        o_cmd.start_tick = 1'b1;
                        n_state          = ST_TICK;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.scan_done && i_sts.walk_done) begin
                    n_state = i_sts.found ? ST_WRITE : ST_SET_OUT;
                end
            end
            ST_WRITE: begin
                o_cmd.write_slot = 1'b1;
                n_state          = ST_SET_OUT;
            end
            ST_SET_OUT: begin
                // The predecessor's link is rewritten while the result waits for space.
                o_cmd.link_prev = i_sts.found;
                if (i_sts.out_free) begin
                    o_cmd.out_set = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (i_sts.k_zero) begin
                    if (i_sts.next_due) begin
                        o_cmd.pop = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_sts.out_free) begin
                    // Send the held expiry; it is the last one unless another is due.
                    o_cmd.out_exp = 1'b1;
                    if (i_sts.next_due) begin
                        o_cmd.pop = 1'b1;
                    end else begin
                        o_cmd.out_last = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sorted_timeout_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sorted timeout scheduler: controller plus datapath.
// Depends on sts_pkg, sts_if, sts_ctrl and sts_datapath.
//
// The block keeps a 32-bit tick counter and a table of SLOT_COUNT timeouts linked
// in deadline order (wrap-aware compare, equal deadlines in arrival order). It works
// on one item at a time. Once a set item is accepted, the block walks the list and
// scans the busy bits for a free slot in parallel, one entry and one slot a cycle,
// until both are finished. It then writes the slot and loads the result (only the
// load for a rejected set), and may wait for the sink. The result is either
// accepted or, with a full table, rejected. A tick item advances time and then
// removes due head entries at one per cycle from the single read port of the entry
// memory while the sink takes the results, up to sixteen expiries per tick, the last
// flagged. Results sit in an output register, so one may wait for the sink while
// the block goes on working.
module sorted_timeout_scheduler_unit import sts_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sts_in_if.sink   i_in,
    sts_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencing of set and tick items.
    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Storage, list walk and result register.
    sts_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_duration  (i_in.duration),
        .i_tag       (i_in.tag),
        .i_class     (i_in.callback_class),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_kind      (o_out.kind),
        .o_tag       (o_out.out_tag),
        .o_class     (o_out.out_class),
        .o_deadline  (o_out.deadline),
        .o_last      (o_out.last)
    );

endmodule
